// ===== design/vrbs_pkg.sv =====
// ----------------------------------------------------------------------------
// Variable record byte stack: shared package
// Sizes, transaction payload types, status codes and the command and status
// groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package vrbs_pkg;

    localparam int STACK_BYTES      = 4096;
    localparam int MAX_RECORD_BYTES = 255;
    localparam int WORD_BYTES       = 8;

    localparam int ROWS    = STACK_BYTES / WORD_BYTES;
    localparam int ADDR_W  = $clog2(STACK_BYTES) + 1;
    localparam int ROW_W   = $clog2(ROWS);
    localparam int LANE_W  = $clog2(WORD_BYTES);
    localparam int LEN_W   = $clog2(MAX_RECORD_BYTES + 2);
    localparam int SIZE_W  = 8;
    localparam int CAP_W   = 13;
    localparam int DATA_W  = 64;
    localparam int BYTES_W = 4;
    localparam int CMP_W   = ((ADDR_W > CAP_W) ? ADDR_W : CAP_W) + 1;

    localparam int CAP_RESET = 4096;

    typedef enum logic
    {
        REQ_PUSH = 1'b0,
        REQ_POP  = 1'b1
    } req_t;

    typedef enum logic [1:0]
    {
        STS_OK        = 2'd0,
        STS_OVERFLOW  = 2'd1,
        STS_UNDERFLOW = 2'd2
    } status_code_t;

    typedef struct packed
    {
        req_t                 req_type;
        logic [DATA_W-1:0]    push_data;
        logic [BYTES_W-1:0]   push_bytes;
        logic                 push_last;
        logic [SIZE_W-1:0]    pop_limit;
    } in_item_t;

    typedef struct packed
    {
        status_code_t         status;
        logic [DATA_W-1:0]    pop_data;
        logic [BYTES_W-1:0]   pop_bytes;
        logic                 last;
    } out_item_t;

    typedef struct packed
    {
        logic push_acc;
        logic pop_acc;
        logic trl_wr;
        logic pop_chk;
        logic word_ld;
    } dp_cmd_t;

    typedef struct packed
    {
        logic push_commit;
        logic pop_stream;
        logic out_valid;
        logic out_last;
    } dp_sts_t;

endpackage

// ===== design/vrbs_ctrl.sv =====
// ----------------------------------------------------------------------------
// Variable record byte stack: controller
// Sequences push trailer writes, pop checks and the word stream of a pop.
// ----------------------------------------------------------------------------
module vrbs_ctrl
    import vrbs_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    input  req_t    req_type,
    output logic    in_ready,
    input  logic    out_ready,
    input  dp_sts_t sts,
    output dp_cmd_t cmd
);

    typedef enum logic [5:0]
    {
        ST_IDLE      = 6'b000001,
        ST_PUSH_TRL  = 6'b000010,
        ST_POP_CHK   = 6'b000100,
        ST_WORD_RD   = 6'b001000,
        ST_WORD_LD   = 6'b010000,
        ST_WORD_WAIT = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign in_ready = (state_reg == ST_IDLE) && (!sts.out_valid || out_ready);
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        cmd.push_acc = accept && (req_type == REQ_PUSH);
        cmd.pop_acc  = accept && (req_type == REQ_POP);
        cmd.trl_wr   = (state_reg == ST_PUSH_TRL);
        cmd.pop_chk  = (state_reg == ST_POP_CHK);
        cmd.word_ld  = (state_reg == ST_WORD_LD);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd.pop_acc)
                begin
                    state_next = ST_POP_CHK;
                end
                else if (cmd.push_acc && sts.push_commit)
                begin
                    state_next = ST_PUSH_TRL;
                end
            end
            ST_PUSH_TRL:
            begin
                state_next = ST_IDLE;
            end
            ST_POP_CHK:
            begin
                state_next = sts.pop_stream ? ST_WORD_RD : ST_IDLE;
            end
            ST_WORD_RD:
            begin
                state_next = ST_WORD_LD;
            end
            ST_WORD_LD:
            begin
                state_next = ST_WORD_WAIT;
            end
            ST_WORD_WAIT:
            begin
                if (sts.out_valid && out_ready)
                begin
                    state_next = sts.out_last ? ST_IDLE : ST_WORD_LD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    a_wait_has_word: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WORD_WAIT) |-> sts.out_valid)
        else $error("Word wait state without a loaded word.");

    a_check_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_POP_CHK) |-> !sts.out_valid)
        else $error("Pop check entered with the output register occupied.");

endmodule

// ===== design/vrbs_dp.sv =====
// ----------------------------------------------------------------------------
// Variable record byte stack: datapath
// Eight byte-lane memory banks, top and pending record state, the capacity
// register, pop checks and the output register.
// ----------------------------------------------------------------------------
module vrbs_dp
    import vrbs_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  in_item_t         in_data,
    input  dp_cmd_t          cmd,
    output dp_sts_t          sts,
    input  logic             cfg_valid,
    input  logic [CAP_W-1:0] cfg_data,
    input  logic             out_ready,
    output logic             out_valid,
    output out_item_t        out_data
);

    logic [CAP_W-1:0]   cap_reg;
    logic [ADDR_W-1:0]  top_reg;
    logic [LEN_W-1:0]   pend_len_reg;
    logic               pend_ovf_reg;
    logic [ADDR_W-1:0]  trl_addr_reg;
    logic [SIZE_W-1:0]  trl_len_reg;
    logic [SIZE_W-1:0]  limit_reg;
    logic [ADDR_W-1:0]  word_addr_reg;
    logic [SIZE_W-1:0]  remain_reg;
    logic [LANE_W-1:0]  rd_lo_reg;
    out_item_t          out_reg;
    logic               out_valid_reg;

    logic [BYTES_W-1:0] n_eff;
    logic [LEN_W-1:0]   room;
    logic               spill;
    logic [LEN_W-1:0]   take;
    logic               ovf_new;
    logic [LEN_W-1:0]   len_new;
    logic [CMP_W-1:0]   need;
    logic [CMP_W-1:0]   cap_eff;
    logic               bad;
    logic [ADDR_W-1:0]  wr_base;
    logic [ADDR_W-1:0]  rd_base;

    logic [7:0]         bank_q [WORD_BYTES];
    logic [7:0]         rot [WORD_BYTES];
    logic [SIZE_W-1:0]  size;
    logic               top_empty;
    logic [ADDR_W-1:0]  top_m1;
    logic [ADDR_W-1:0]  pop_base;
    status_code_t       chk_status;
    logic [BYTES_W-1:0] cnt;
    logic [DATA_W-1:0]  word_data;

    // Push piece bookkeeping.
    always_comb
    begin
        n_eff = (in_data.push_bytes > BYTES_W'(WORD_BYTES)) ?
                BYTES_W'(WORD_BYTES) : in_data.push_bytes;
        room  = (pend_len_reg < LEN_W'(MAX_RECORD_BYTES)) ?
                LEN_W'(MAX_RECORD_BYTES) - pend_len_reg : '0;
        spill   = LEN_W'(n_eff) > room;
        take    = spill ? room : LEN_W'(n_eff);
        ovf_new = pend_ovf_reg || spill;
        len_new = spill ? LEN_W'(MAX_RECORD_BYTES + 1) : pend_len_reg + take;
        need    = CMP_W'(top_reg) + CMP_W'(len_new) + CMP_W'(1);
        cap_eff = (CMP_W'(cap_reg) > CMP_W'(STACK_BYTES)) ?
                  CMP_W'(STACK_BYTES) : CMP_W'(cap_reg);
        bad     = ovf_new || (len_new > LEN_W'(MAX_RECORD_BYTES)) || (need > cap_eff);
        wr_base = top_reg + ADDR_W'(pend_len_reg);
        rd_base = cmd.pop_acc ? top_reg - ADDR_W'(1) : word_addr_reg;
    end

    for (genvar b = 0; b < WORD_BYTES; b++)
    begin : g_bank
        logic [7:0]        mem [ROWS];
        logic [7:0]        q_reg;
        logic [LANE_W-1:0] wr_off;
        logic [ADDR_W-1:0] wr_addr;
        logic [LANE_W-1:0] rd_off;
        logic [ADDR_W-1:0] rd_addr;
        logic              wr_en;
        logic [ROW_W-1:0]  wr_row;
        logic [7:0]        wr_byte;

        always_comb
        begin
            wr_off  = LANE_W'(b) - wr_base[LANE_W-1:0];
            wr_addr = wr_base + ADDR_W'(wr_off);
            rd_off  = LANE_W'(b) - rd_base[LANE_W-1:0];
            rd_addr = rd_base + ADDR_W'(rd_off);
            if (cmd.trl_wr)
            begin
                wr_en   = (trl_addr_reg[LANE_W-1:0] == LANE_W'(b));
                wr_row  = trl_addr_reg[LANE_W +: ROW_W];
                wr_byte = trl_len_reg;
            end
            else
            begin
                wr_en   = cmd.push_acc && (LEN_W'(wr_off) < take) &&
                          (wr_addr < ADDR_W'(STACK_BYTES));
                wr_row  = wr_addr[LANE_W +: ROW_W];
                wr_byte = in_data.push_data[8*wr_off +: 8];
            end
        end

        always_ff @(posedge clk)
        begin
            if (wr_en)
            begin
                mem[wr_row] <= wr_byte;
            end
            q_reg <= mem[rd_addr[LANE_W +: ROW_W]];
        end

        assign bank_q[b] = q_reg;
    end

    // Byte lanes back into record order, then pop checks and word assembly.
    always_comb
    begin
        for (int k = 0; k < WORD_BYTES; k++)
        begin
            rot[k] = bank_q[LANE_W'(rd_lo_reg + LANE_W'(k))];
        end
        size      = rot[0];
        top_empty = (top_reg == '0) || (top_reg > ADDR_W'(STACK_BYTES));
        top_m1    = top_reg - ADDR_W'(1);
        pop_base  = top_m1 - ADDR_W'(size);
        if (top_empty)
        begin
            chk_status = STS_UNDERFLOW;
        end
        else if (size > limit_reg)
        begin
            chk_status = STS_OVERFLOW;
        end
        else if (top_m1 < ADDR_W'(size))
        begin
            chk_status = STS_UNDERFLOW;
        end
        else
        begin
            chk_status = STS_OK;
        end
        cnt = (remain_reg > SIZE_W'(WORD_BYTES)) ? BYTES_W'(WORD_BYTES) :
              BYTES_W'(remain_reg);
        for (int k = 0; k < WORD_BYTES; k++)
        begin
            word_data[8*k +: 8] = (BYTES_W'(k) < cnt) ? rot[k] : 8'h00;
        end
    end

    always_comb
    begin
        sts.push_commit = in_data.push_last && !bad;
        sts.pop_stream  = (chk_status == STS_OK) && (size != '0);
        sts.out_valid   = out_valid_reg;
        sts.out_last    = out_reg.last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg       <= CAP_W'(CAP_RESET);
            top_reg       <= '0;
            pend_len_reg  <= '0;
            pend_ovf_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                cap_reg <= cfg_data;
            end
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cmd.push_acc)
            begin
                out_valid_reg <= 1'b1;
                if (in_data.push_last)
                begin
                    pend_len_reg <= '0;
                    pend_ovf_reg <= 1'b0;
                    if (!bad)
                    begin
                        top_reg <= ADDR_W'(need);
                    end
                end
                else
                begin
                    pend_len_reg <= len_new;
                    pend_ovf_reg <= ovf_new;
                end
            end
            if (cmd.pop_acc)
            begin
                pend_len_reg <= '0;
                pend_ovf_reg <= 1'b0;
            end
            if (cmd.pop_chk)
            begin
                if (chk_status == STS_OK)
                begin
                    top_reg <= pop_base;
                end
                if (!sts.pop_stream)
                begin
                    out_valid_reg <= 1'b1;
                end
            end
            if (cmd.word_ld)
            begin
                out_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rd_lo_reg <= rd_base[LANE_W-1:0];
        if (cmd.push_acc)
        begin
            trl_addr_reg      <= top_reg + ADDR_W'(len_new);
            trl_len_reg       <= len_new[SIZE_W-1:0];
            out_reg.status    <= (in_data.push_last && bad) ? STS_OVERFLOW : STS_OK;
            out_reg.pop_data  <= '0;
            out_reg.pop_bytes <= '0;
            out_reg.last      <= 1'b1;
        end
        if (cmd.pop_acc)
        begin
            limit_reg <= in_data.pop_limit;
        end
        if (cmd.pop_chk)
        begin
            word_addr_reg     <= pop_base;
            remain_reg        <= size;
            out_reg.status    <= chk_status;
            out_reg.pop_data  <= '0;
            out_reg.pop_bytes <= '0;
            out_reg.last      <= 1'b1;
        end
        if (cmd.word_ld)
        begin
            out_reg.status    <= STS_OK;
            out_reg.pop_data  <= word_data;
            out_reg.pop_bytes <= cnt;
            out_reg.last      <= (remain_reg <= SIZE_W'(WORD_BYTES));
            remain_reg        <= remain_reg - SIZE_W'(cnt);
            word_addr_reg     <= word_addr_reg + ADDR_W'(WORD_BYTES);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    a_top_bound: assert property (@(posedge clk) disable iff (!rst_n)
        top_reg <= ADDR_W'(STACK_BYTES))
        else $error("Top of stack beyond the memory.");

    a_ovf_len: assert property (@(posedge clk) disable iff (!rst_n)
        pend_ovf_reg |-> (pend_len_reg == LEN_W'(MAX_RECORD_BYTES + 1)))
        else $error("Pending overflow without a saturated length.");

    a_word_bytes: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.word_ld |=> (out_valid_reg && (out_reg.pop_bytes != '0)))
        else $error("Streamed word carries no bytes.");

endmodule

// ===== design/variable_record_byte_stack_unit.sv =====
// ----------------------------------------------------------------------------
// Variable record byte stack unit
// Byte-addressed LIFO of variable-length records, each stored with a
// one-byte length trailer; records are pushed in pieces and popped in words.
//
//   Channel  Handshake              Payload
//   in       in_valid / in_ready    in_data   (in_item_t)
//   out      out_valid / out_ready  out_data  (out_item_t)
//   cfg      cfg_valid / cfg_ready  cfg_data  (capacity in bytes)
//
// A committed final push piece is followed by a trailer write state, since
// eight data bytes fill all memory banks. A pop reads and checks the trailer
// in the pop check state, then passes a word read state and, per output word,
// the load and wait states, set by the registered read of the byte-lane banks.
// Reset clears the top pointer and the pending record; memory is not cleared.
// A stalled output holds the datapath; a new item waits until the result
// register is free or being taken in the same cycle.
// ----------------------------------------------------------------------------
module variable_record_byte_stack_unit
    import vrbs_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  in_item_t         in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output out_item_t        out_data,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [CAP_W-1:0] cfg_data
);

    dp_cmd_t cmd;
    dp_sts_t sts;

    assign cfg_ready = 1'b1;

    vrbs_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .req_type  (in_data.req_type),
        .in_ready  (in_ready),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    vrbs_dp u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cmd       (cmd),
        .sts       (sts),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .out_data  (out_data)
    );

endmodule
